[sv/afrm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afrm_pkg
// Shared widths and helpers for the frame alignment rotation matrix unit.
// ----------------------------------------------------------------------------
package afrm_pkg;

    localparam int FRAC_BITS_DEF = 14;

    // normalized component magnitude, its square and a row's sum of squares
    localparam int MAG_W  = 31;
    localparam int MAG2_W = 2 * MAG_W;
    localparam int SQ_W   = 64;

    localparam int FIELD_W = 16;
    localparam int IN_W    = 6 * FIELD_W;
    localparam int OUT_W   = 9 * FIELD_W;

    typedef logic signed [FIELD_W-1:0] field_t;

    // cycles spent in one ratio lane: restoring divide, then root search
    function automatic int lane_latency(input int frac);
        return (2 * frac + 3) + (frac + 1);
    endfunction

endpackage
`default_nettype wire

[sv/afrm_ratio_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afrm_ratio_lane
// Pipelined rounding of mag * 2^F / sqrt(sq): a restoring divide yields
// floor(mag^2 * 2^(2F+2) / sq), then a bit search finds the largest m with
// (2m-1)^2 not above it, capped at 1.0.
// ----------------------------------------------------------------------------
module afrm_ratio_lane #(
    parameter int FRAC_BITS = afrm_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [afrm_pkg::MAG2_W-1:0]  mag2,
    input  logic [afrm_pkg::SQ_W-1:0]    sq,
    input  logic                         neg,
    output logic [FRAC_BITS:0]           ratio,
    output logic                         ratio_neg
);
    import afrm_pkg::*;

    localparam int DIV_N  = 2 * FRAC_BITS + 3;
    localparam int QW     = DIV_N;
    localparam int RW     = SQ_W + 1;
    localparam int ROOT_N = FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + 2;
    localparam int D2W    = 2 * DW;
    localparam logic [FRAC_BITS:0] TOP = {1'b1, {FRAC_BITS{1'b0}}};

    logic [RW-1:0]      rem_reg  [DIV_N];
    logic [QW-1:0]      quo_reg  [DIV_N];
    logic [SQ_W-1:0]    den_reg  [DIV_N];
    logic               dneg_reg [DIV_N];

    logic [FRAC_BITS:0] root_reg [ROOT_N];
    logic [QW-1:0]      rq_reg   [ROOT_N];
    logic               rneg_reg [ROOT_N];

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [RW-1:0]   rem_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   rem_next;
        logic [QW-1:0]   quo_in;
        logic [SQ_W-1:0] den_in;
        logic            neg_in;
        logic            qbit;

        if (k == 0) begin : g_first
            assign rem_in = RW'(mag2);
            assign rem_sh = rem_in;
            assign quo_in = '0;
            assign den_in = sq;
            assign neg_in = neg;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign rem_sh = {rem_in[RW-2:0], 1'b0};
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = dneg_reg[k-1];
        end

        always_comb begin
            qbit     = (rem_sh >= RW'(den_in));
            rem_next = qbit ? (rem_sh - RW'(den_in)) : rem_sh;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= {quo_in[QW-2:0], qbit};
                den_reg[k]  <= den_in;
                dneg_reg[k] <= neg_in;
            end
        end
    end

    for (genvar j = 0; j < ROOT_N; j++) begin : g_root
        logic [FRAC_BITS:0] root_in;
        logic [FRAC_BITS:0] cand;
        logic [FRAC_BITS:0] root_next;
        logic [QW-1:0]      q_in;
        logic               neg_in;
        logic [DW-1:0]      dv;
        logic [D2W-1:0]     dsq;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign q_in    = quo_reg[DIV_N-1];
            assign neg_in  = dneg_reg[DIV_N-1];
        end else begin : g_rest
            assign root_in = root_reg[j-1];
            assign q_in    = rq_reg[j-1];
            assign neg_in  = rneg_reg[j-1];
        end

        always_comb begin
            cand      = root_in | ((FRAC_BITS + 1)'(1) << (FRAC_BITS - j));
            dv        = {1'b0, cand} + {1'b0, cand} - DW'(1);
            dsq       = D2W'(dv) * D2W'(dv);
            root_next = ((cand <= TOP) && (dsq <= D2W'(q_in))) ? cand : root_in;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[j] <= root_next;
                rq_reg[j]   <= q_in;
                rneg_reg[j] <= neg_in;
            end
        end
    end

    assign ratio     = root_reg[ROOT_N-1];
    assign ratio_neg = rneg_reg[ROOT_N-1];

endmodule
`default_nettype wire

[sv/align_frame_rotation_matrix_unit.sv]
`default_nettype none
// Throughput: one item per cycle; every stage is a register stage and the
// divide and root search advance one quotient or root bit per stage.
// A stalled result holds the whole pipeline in place.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
// align_frame_rotation_matrix_unit
// Rotation matrix in Q1.F whose rows are the unit vectors of p, of q made
// perpendicular to p, and of p x q; identity with a flag when degenerate.
// ----------------------------------------------------------------------------
module align_frame_rotation_matrix_unit #(
    parameter int FRAC_BITS = afrm_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // primary_x, primary_y, primary_z, plane_x, plane_y, plane_z
    input  logic [afrm_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [afrm_pkg::OUT_W-1:0]  m_tdata,
    // degenerate
    output logic [0:0]                  m_tuser
);
    import afrm_pkg::*;

    localparam int LANE_LAT = lane_latency(FRAC_BITS);
    localparam int FRONT_N  = 10;
    localparam int PIPE_D   = FRONT_N + LANE_LAT + 1;
    localparam int MW       = 51;
    localparam logic [MW-1:0] LIM = MW'((64'(1) << MAG_W) - 64'(1));
    localparam logic [FIELD_W-1:0] ONE = FIELD_W'(64'(1) << FRAC_BITS);
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic en;
    logic vld_reg [PIPE_D];
    logic deg_reg [PIPE_D];

    // stage data
    field_t                  p1_reg [3], q1_reg [3];
    logic signed [31:0]      pp2_reg [3], pq2_reg [3], xa2_reg [3], xb2_reg [3];
    field_t                  p2_reg [3], q2_reg [3];
    logic signed [33:0]      pp3_reg, pq3_reg;
    logic signed [32:0]      c3_reg [3];
    field_t                  p3_reg [3], q3_reg [3];
    logic signed [49:0]      qpp4_reg [3], ppq4_reg [3];
    logic signed [32:0]      c4_reg [3];
    field_t                  p4_reg [3];
    logic signed [50:0]      w5_reg [3];
    logic signed [32:0]      c5_reg [3];
    field_t                  p5_reg [3];
    logic [MW-1:0]           mag6_reg [3][3];
    logic [MW-1:0]           mag7_reg [3][3];
    logic [MAG_W-1:0]        mag8_reg [3][3];
    logic [MAG2_W-1:0]       sqr9_reg [3][3];
    logic [MAG2_W-1:0]       sqr10_reg [3][3];
    logic [SQ_W-1:0]         sq10_reg [3];
    logic                    neg6_reg [3][3], neg7_reg [3][3], neg8_reg [3][3];
    logic                    neg9_reg [3][3], neg10_reg [3][3];
    logic [FIELD_W-1:0]      out_reg [9];

    logic [FIELD_W-1:0]      out_next [9];
    logic                    deg_next;
    logic signed [MW-1:0]    sv6 [3][3];
    logic [MW-1:0]           mag7_next [3][3];
    logic [MAG_W-1:0]        mag8_next [3][3];
    logic [FRAC_BITS:0]      ratio [3][3];
    logic                    ratio_neg [3][3];

    assign en       = !vld_reg[PIPE_D-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_D-1];
    assign m_tuser  = deg_reg[PIPE_D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_D; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_D; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // flag the cases with no unique frame
    always_comb begin
        deg_next = (pp3_reg == 34'sd0) ||
                   ((c3_reg[0] == 33'sd0) && (c3_reg[1] == 33'sd0) && (c3_reg[2] == 33'sd0));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                deg_reg[i] <= 1'b0;
            end
            deg_reg[3] <= deg_next;
            for (int i = 4; i < PIPE_D; i++) begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    // signed rows: p, w, c
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sv6[0][i] = MW'(p5_reg[i]);
            sv6[1][i] = w5_reg[i];
            sv6[2][i] = MW'(c5_reg[i]);
        end
    end

    // coarse normalize: drop 16, 8, 4 bits while the largest stays too big
    always_comb begin
        logic [MW-1:0] orv;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                mag7_next[r][i] = mag6_reg[r][i];
            end
            orv = mag6_reg[r][0] | mag6_reg[r][1] | mag6_reg[r][2];
            if ((orv >> 16) > LIM) begin
                orv = orv >> 16;
                for (int i = 0; i < 3; i++) mag7_next[r][i] = mag7_next[r][i] >> 16;
            end
            if ((orv >> 8) > LIM) begin
                orv = orv >> 8;
                for (int i = 0; i < 3; i++) mag7_next[r][i] = mag7_next[r][i] >> 8;
            end
            if ((orv >> 4) > LIM) begin
                orv = orv >> 4;
                for (int i = 0; i < 3; i++) mag7_next[r][i] = mag7_next[r][i] >> 4;
            end
        end
    end

    // fine normalize: 2, 1, 1 bits, until every magnitude is below 2^31
    always_comb begin
        logic [MW-1:0] orv;
        logic [MW-1:0] mv [3];
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                mv[i] = mag7_reg[r][i];
            end
            orv = mv[0] | mv[1] | mv[2];
            if ((orv >> 2) > LIM) begin
                orv = orv >> 2;
                for (int i = 0; i < 3; i++) mv[i] = mv[i] >> 2;
            end
            if ((orv >> 1) > LIM) begin
                orv = orv >> 1;
                for (int i = 0; i < 3; i++) mv[i] = mv[i] >> 1;
            end
            if (orv > LIM) begin
                for (int i = 0; i < 3; i++) mv[i] = mv[i] >> 1;
            end
            for (int i = 0; i < 3; i++) begin
                mag8_next[r][i] = mv[i][MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= field_t'(s_tdata[i*FIELD_W +: FIELD_W]);
                q1_reg[i] <= field_t'(s_tdata[(i+3)*FIELD_W +: FIELD_W]);

                pp2_reg[i] <= p1_reg[i] * p1_reg[i];
                pq2_reg[i] <= p1_reg[i] * q1_reg[i];
                xa2_reg[i] <= p1_reg[NXT[i]] * q1_reg[PRV[i]];
                xb2_reg[i] <= p1_reg[PRV[i]] * q1_reg[NXT[i]];
                p2_reg[i]  <= p1_reg[i];
                q2_reg[i]  <= q1_reg[i];

                c3_reg[i] <= 33'(xa2_reg[i]) - 33'(xb2_reg[i]);
                p3_reg[i] <= p2_reg[i];
                q3_reg[i] <= q2_reg[i];

                qpp4_reg[i] <= 50'(q3_reg[i]) * 50'(pp3_reg);
                ppq4_reg[i] <= 50'(p3_reg[i]) * 50'(pq3_reg);
                c4_reg[i]   <= c3_reg[i];
                p4_reg[i]   <= p3_reg[i];

                w5_reg[i] <= 51'(qpp4_reg[i]) - 51'(ppq4_reg[i]);
                c5_reg[i] <= c4_reg[i];
                p5_reg[i] <= p4_reg[i];
            end
            pp3_reg <= 34'(pp2_reg[0]) + 34'(pp2_reg[1]) + 34'(pp2_reg[2]);
            pq3_reg <= 34'(pq2_reg[0]) + 34'(pq2_reg[1]) + 34'(pq2_reg[2]);

            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    neg6_reg[r][i] <= sv6[r][i][MW-1];
                    mag6_reg[r][i] <= sv6[r][i][MW-1] ? MW'(-sv6[r][i]) : MW'(sv6[r][i]);
                    mag7_reg[r][i] <= mag7_next[r][i];
                    neg7_reg[r][i] <= neg6_reg[r][i];
                    mag8_reg[r][i] <= mag8_next[r][i];
                    neg8_reg[r][i] <= neg7_reg[r][i];
                    sqr9_reg[r][i] <= MAG2_W'(mag8_reg[r][i]) * MAG2_W'(mag8_reg[r][i]);
                    neg9_reg[r][i] <= neg8_reg[r][i];
                    sqr10_reg[r][i] <= sqr9_reg[r][i];
                    neg10_reg[r][i] <= neg9_reg[r][i];
                end
                sq10_reg[r] <= SQ_W'(sqr9_reg[r][0]) + SQ_W'(sqr9_reg[r][1])
                             + SQ_W'(sqr9_reg[r][2]);
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar i = 0; i < 3; i++) begin : g_col
            afrm_ratio_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk      (aclk),
                .en        (en),
                .mag2      (sqr10_reg[r][i]),
                .sq        (sq10_reg[r]),
                .neg       (neg10_reg[r][i]),
                .ratio     (ratio[r][i]),
                .ratio_neg (ratio_neg[r][i])
            );
        end
    end

    // apply signs, mask to the field width, or force the identity
    always_comb begin
        logic [63:0] rv;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                rv = 64'(ratio[r][i]);
                if (ratio_neg[r][i]) begin
                    rv = ~rv + 64'(1);
                end
                if (deg_reg[PIPE_D-2]) begin
                    out_next[r*3+i] = (r == i) ? ONE : '0;
                end else begin
                    out_next[r*3+i] = rv[FIELD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                out_reg[k] <= out_next[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m_tdata[k*FIELD_W +: FIELD_W] = out_reg[k];
        end
    end

endmodule
`default_nettype wire

[test/afrm_checker.sv]
// ----------------------------------------------------------------------------
// afrm_checker
// Watches both streams of the rotation matrix unit, predicts each matrix from
// the accepted vector pair with exact integer math and compares in order.
// ----------------------------------------------------------------------------
module afrm_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [afrm_pkg::IN_W-1:0]   s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [afrm_pkg::OUT_W-1:0]  m_tdata,
    input  logic [0:0]                  m_tuser,
    output int                          fail_count,
    output int                          pending_count,
    output int                          degenerate_count
);
    import afrm_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic [OUT_W-1:0] mat;
        logic             degen;
    } matrix_t;

    matrix_t expected_matrices[$];

    // nearest integer to mag * 2^FRAC / sqrt(sq), bitwise root search
    function automatic logic [15:0] unit_entry(input logic [63:0] mag, input logic [63:0] sq);
        logic [63:0]  m;
        logic [63:0]  cand;
        logic [63:0]  d;
        logic [127:0] lhs;
        logic [127:0] rhs;
        m = 0;
        rhs = (128'(mag) * 128'(mag)) << (2 * FRAC + 2);
        for (int b = FRAC; b >= 0; b--) begin
            cand = m | (64'd1 << b);
            if (cand <= (64'd1 << FRAC)) begin
                d = 2 * cand - 1;
                lhs = 128'(d * d) * 128'(sq);
                if (lhs <= rhs) m = cand;
            end
        end
        return m[15:0];
    endfunction

    function automatic logic [47:0] unit_row(input logic signed [63:0] u0,
                                             input logic signed [63:0] u1,
                                             input logic signed [63:0] u2);
        logic signed [63:0] u[3];
        logic [63:0] mag[3];
        logic [63:0] mx;
        logic [63:0] sq;
        logic [15:0] r;
        logic [47:0] row;
        u[0] = u0; u[1] = u1; u[2] = u2;
        mx = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = u[i] < 0 ? -u[i] : u[i];
            if (mag[i] > mx) mx = mag[i];
        end
        while (mx >= 64'h8000_0000) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
        for (int i = 0; i < 3; i++) begin
            r = unit_entry(mag[i], sq);
            row[16*i +: 16] = u[i] < 0 ? -r : r;
        end
        return row;
    endfunction

    function automatic matrix_t frame_matrix(input logic [IN_W-1:0] vecs);
        logic signed [63:0] p[3];
        logic signed [63:0] q[3];
        logic signed [63:0] c[3];
        logic signed [63:0] w[3];
        logic signed [63:0] pp;
        logic signed [63:0] pq;
        matrix_t res;
        for (int i = 0; i < 3; i++) begin
            p[i] = 64'(signed'(vecs[16*i +: 16]));
            q[i] = 64'(signed'(vecs[16*(i+3) +: 16]));
        end
        pp = p[0]*p[0] + p[1]*p[1] + p[2]*p[2];
        pq = p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
        c[0] = p[1]*q[2] - p[2]*q[1];
        c[1] = p[2]*q[0] - p[0]*q[2];
        c[2] = p[0]*q[1] - p[1]*q[0];
        res = '0;
        if (pp == 0 || (c[0] == 0 && c[1] == 0 && c[2] == 0)) begin
            for (int i = 0; i < 9; i += 4) res.mat[16*i +: 16] = 16'(1 << FRAC);
            res.degen = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) w[i] = q[i]*pp - p[i]*pq;
            res.mat[47:0]   = unit_row(p[0], p[1], p[2]);
            res.mat[95:48]  = unit_row(w[0], w[1], w[2]);
            res.mat[143:96] = unit_row(c[0], c[1], c[2]);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        degenerate_count = 0;
    end

    assign pending_count = expected_matrices.size();

    always @(posedge aclk) begin
        matrix_t want;
        if (aresetn && s_tvalid && s_tready)
            expected_matrices.push_back(frame_matrix(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_matrices.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = expected_matrices.pop_front();
                if (want.degen) degenerate_count++;
                for (int i = 0; i < 9; i++)
                    if (m_tdata[16*i +: 16] !== want.mat[16*i +: 16])
                        report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                                        signed'(m_tdata[16*i +: 16]),
                                        signed'(want.mat[16*i +: 16]));
                if (m_tuser[0] !== want.degen)
                    report_mismatch("degenerate", m_tuser[0], want.degen);
            end
        end
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives vector pairs into the rotation matrix unit under varying idle and
// stall patterns; the checker predicts and compares every matrix.
// ----------------------------------------------------------------------------
module tb_top;
    import afrm_pkg::*;

    localparam int LATENCY = 3 * FRAC_BITS_DEF + 15;
    localparam int RANDOM_ITEMS = 750;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0]       m_tuser;
    int               fail_count;
    int               pending_count;
    int               degenerate_count;
    int               send_idle_pct;
    int               stall_pct;
    int               sent_count;

    align_frame_rotation_matrix_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    afrm_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .degenerate_count(degenerate_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // random receiver stall
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // hold each item until accepted, with random gaps before it;
    // called at a rising edge, returns at the accepting edge
    task automatic send_pair(input logic [IN_W-1:0] vecs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vecs;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic send_vecs(input int px, input int py, input int pz,
                             input int qx, input int qy, input int qz);
        send_pair({16'(qz), 16'(qy), 16'(qx), 16'(pz), 16'(py), 16'(px)});
    endtask

    task automatic send_random(input int count);
        logic [15:0] c[6];
        int k;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 6; i++) c[i] = rand_comp();
            k = $urandom_range(9);
            // sign-flipped or tripled (parallel) reference, zero primary
            if (k == 0) begin
                for (int i = 0; i < 3; i++) c[i+3] = ($urandom_range(1)) ? c[i] : -c[i];
            end else if (k == 1) begin
                for (int i = 0; i < 3; i++) c[i] = 16'(signed'(c[i]) >>> 8);
                for (int i = 0; i < 3; i++) c[i+3] = 16'(signed'(c[i]) * 3);
            end else if (k == 2) begin
                c[0] = 0; c[1] = 0; c[2] = 0;
            end
            send_pair({c[5], c[4], c[3], c[2], c[1], c[0]});
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        sent_count = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_vecs(1, 0, 0, 0, 1, 0);
        send_vecs(-1, 0, 0, 0, 1, 0);
        send_vecs(5, 0, 0, 0, 0, -7);
        send_vecs(-32768, 0, 0, 0, -32768, 0);
        send_vecs(32767, 32767, 32767, -32768, 32767, -32768);
        send_vecs(-32768, -32768, -32768, 32767, -32768, 32767);
        send_vecs(0, 0, 0, 3, 4, 5);
        send_vecs(0, 0, 0, 0, 0, 0);
        send_vecs(3, 4, 5, 0, 0, 0);
        send_vecs(3, 4, 5, 6, 8, 10);
        send_vecs(3, 4, 5, -3, -4, -5);
        send_vecs(0, 1, 0, 1, 0, 0);
        send_vecs(0, 0, -1, 1, 1, 0);
        send_vecs(1, 1, 1, 1, 0, 0);
        send_vecs(-32768, 32767, 1, 2, -32768, 32767);
        send_vecs(100, -200, 300, -400, 500, -600);

        send_idle_pct = 0;  stall_pct = 0;  send_random(RANDOM_ITEMS / 4);
        send_idle_pct = 82; stall_pct = 0;  send_random(RANDOM_ITEMS / 4);
        send_idle_pct = 0;  stall_pct = 82; send_random(RANDOM_ITEMS / 4);
        send_idle_pct = 20; stall_pct = 20; send_random(RANDOM_ITEMS / 4);
        s_tvalid <= 1'b0;

        stall_pct = 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("sent %0d vector pairs, %0d degenerate, over four idle/stall phases",
                 sent_count, degenerate_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout waiting for results");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
sv/afrm_pkg.sv
sv/afrm_ratio_lane.sv
sv/align_frame_rotation_matrix_unit.sv
test/afrm_checker.sv
test/tb_top.sv
